FILE: src/bwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_pkg
// Shared types and constants for the brace word tokenizer.
// ----------------------------------------------------------------------------
package bwt_pkg;

    localparam int MAX_LINE  = 1024;
    localparam int MAX_DEPTH = 255;

    localparam int POS_W   = $clog2(MAX_LINE + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    localparam int CH_W     = 8;
    localparam int BASE_W   = 16;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int STATUS_W = 3;
    localparam int ERRPOS_W = 17;

    localparam int OUT_BITS   = START_W + LEN_W + STATUS_W + ERRPOS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CH_W-1:0] CH_OPEN  = 8'h7b;
    localparam logic [CH_W-1:0] CH_CLOSE = 8'h7d;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING = 3'd0,
        ST_DONE    = 3'd1,
        ST_BRACE   = 3'd2,
        ST_END     = 3'd3,
        ST_DEPTH   = 3'd4,
        ST_LONG    = 3'd5
    } status_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            end_of_line;
    } item_t;

    typedef struct packed {
        logic                token_valid;
        logic [START_W-1:0]  token_start;
        logic [LEN_W-1:0]    token_length;
        status_t             status;
        logic [ERRPOS_W-1:0] error_position;
    } result_t;

endpackage

FILE: src/bwt_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_in_stage
// Input register: holds one accepted item until the step logic takes it.
// ----------------------------------------------------------------------------
module bwt_in_stage
    import bwt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  load,
    input  item_t item_in,
    input  logic  take,
    output logic  valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

FILE: src/bwt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_step
// Line state and the per-byte tokenizer decision, one item per cycle while step is high.
// ----------------------------------------------------------------------------
module bwt_step
    import bwt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_data,
    input  logic              step,
    input  item_t             item,
    output result_t           result
);

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_BARE,
        MODE_BRACED,
        MODE_FINISHED
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [POS_W-1:0]   word_start_reg, word_start_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [BASE_W-1:0]  base_reg;

    logic             is_space;
    logic             err;
    logic             tok;
    status_t          status;
    logic [POS_W-1:0] length;

    assign is_space = (item.ch == CH_SPACE) || (item.ch == CH_TAB) ||
                      (item.ch == CH_CR) || (item.ch == CH_LF);
    assign length   = position_reg - word_start_reg;

    always_comb begin
        mode_next       = mode_reg;
        position_next   = position_reg;
        word_start_next = word_start_reg;
        depth_next      = depth_reg;
        tok             = 1'b0;
        err             = 1'b0;
        status          = ST_RUNNING;
        if (item.end_of_line) begin
            case (mode_reg)
                MODE_BETWEEN: status = ST_DONE;
                MODE_BARE: begin
                    status = ST_DONE;
                    tok    = 1'b1;
                end
                MODE_BRACED: begin
                    status = ST_END;
                    err    = 1'b1;
                end
                default: status = ST_RUNNING;
            endcase
            mode_next       = MODE_BETWEEN;
            position_next   = '0;
            word_start_next = '0;
            depth_next      = '0;
        end else if (mode_reg == MODE_FINISHED) begin
            // bytes after a finish are dropped
        end else if (position_reg >= POS_W'(MAX_LINE)) begin
            status    = ST_LONG;
            err       = 1'b1;
            mode_next = MODE_FINISHED;
        end else begin
            position_next = position_reg + POS_W'(1);
            case (mode_reg)
                MODE_BETWEEN: begin
                    if (is_space) begin
                        mode_next = MODE_BETWEEN;
                    end else if (item.ch == CH_HASH) begin
                        status    = ST_DONE;
                        mode_next = MODE_FINISHED;
                    end else if (item.ch == CH_OPEN) begin
                        depth_next      = DEPTH_W'(1);
                        word_start_next = position_reg + POS_W'(1);
                        mode_next       = MODE_BRACED;
                    end else begin
                        word_start_next = position_reg;
                        mode_next       = MODE_BARE;
                    end
                end
                MODE_BARE: begin
                    if (is_space) begin
                        tok       = 1'b1;
                        mode_next = MODE_BETWEEN;
                    end else if (item.ch == CH_OPEN || item.ch == CH_CLOSE) begin
                        status    = ST_BRACE;
                        err       = 1'b1;
                        mode_next = MODE_FINISHED;
                    end
                end
                default: begin
                    if (item.ch == CH_OPEN) begin
                        if (depth_reg >= DEPTH_W'(MAX_DEPTH)) begin
                            status    = ST_DEPTH;
                            err       = 1'b1;
                            mode_next = MODE_FINISHED;
                        end else begin
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end else if (item.ch == CH_CLOSE) begin
                        // depth is at least one inside braces
                        depth_next = depth_reg - DEPTH_W'(1);
                        if (depth_reg == DEPTH_W'(1)) begin
                            tok       = 1'b1;
                            mode_next = MODE_BETWEEN;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.token_valid    = tok;
        result.token_start    = tok ? word_start_reg[START_W-1:0] : '0;
        result.token_length   = tok ? LEN_W'(length) : '0;
        result.status         = status;
        result.error_position = err ? (ERRPOS_W'(base_reg) + ERRPOS_W'(position_reg)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_BETWEEN;
            position_reg   <= '0;
            word_start_reg <= '0;
            depth_reg      <= '0;
            base_reg       <= '0;
        end else begin
            if (step) begin
                mode_reg       <= mode_next;
                position_reg   <= position_next;
                word_start_reg <= word_start_next;
                depth_reg      <= depth_next;
            end
            if (cfg_we) begin
                base_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: src/bwt_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_out_stage
// Result register: holds one finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module bwt_out_stage
    import bwt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    input  logic    taken,
    output logic    valid,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (taken) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

FILE: src/brace_word_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_word_tokenizer_unit
// Splits a command line, one byte per item, into bare and braced words.
// ----------------------------------------------------------------------------
// usage:
//   s_ side takes one item per cycle: s_tdata[7:0] is the byte, s_tlast
//   marks the end of the line (byte ignored), which also restarts the line.
//   m_ side gives exactly one result item per input item, in order.
//   cfg_valid/cfg_data writes position_base; cfg_ready is always high.
//   write it only while no item is in flight.
// path: input register, step logic, then result register to m_.
// throughput: one item per cycle while m_ is not stalled; the step logic
//   updates the line state (mode, position, word start, depth) per item.
// stall: a held result keeps m_tdata stable; one more item waits in the
//   input register, then s_tready drops until m_tready returns.
// reset: aresetn low clears both stages, the line state and position_base.
// ----------------------------------------------------------------------------
module brace_word_tokenizer_unit
    import bwt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // ch
    input  logic                  s_tlast,   // end_of_line
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // token_start, token_length, status, error_position, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // token_valid
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BASE_W-1:0]     cfg_data   // position_base
);

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    out_free;
    result_t step_result;
    result_t out_result;

    assign in_item.ch          = s_tdata;
    assign in_item.end_of_line = s_tlast;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = held_valid && out_free;
    assign s_tready = !held_valid || out_free;
    assign cfg_ready = 1'b1;

    bwt_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_tvalid && s_tready),
        .item_in  (in_item),
        .take     (advance),
        .valid    (held_valid),
        .item_out (held_item)
    );

    bwt_step u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (advance),
        .item     (held_item),
        .result   (step_result)
    );

    bwt_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (step_result),
        .taken      (m_tready),
        .valid      (m_tvalid),
        .result_out (out_result)
    );

    assign m_tuser = out_result.token_valid;
    assign m_tdata = {(OUT_DATA_W - OUT_BITS)'(0), out_result.error_position,
                      out_result.status, out_result.token_length,
                      out_result.token_start};

`ifndef NO_ASSERTIONS
    // a token ends only on a running or clean end
    a_tok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result.token_valid) |->
        (out_result.status == ST_RUNNING || out_result.status == ST_DONE))
        else $error("token with error status");

    // no token fields without a token
    a_tok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_result.token_valid) |->
        (out_result.token_start == '0 && out_result.token_length == '0))
        else $error("token fields set without token");

    // error position only with an error status
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_result.status == ST_RUNNING ||
                      out_result.status == ST_DONE)) |->
        (out_result.error_position == '0))
        else $error("error position without error");

    // a held item is not dropped while the output stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_valid && !out_free) |=> held_valid)
        else $error("input item lost during stall");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brace_word_tokenizer_unit.
// A short table of hand-picked bytes runs first, then random command lines
// (mostly well-formed words, some noise and broken lines) and long runs that
// push the line length and brace nesting to their limits. position_base
// is rewritten between phases. Pinned table rows are checked against their
// listed result, others against a cycle-free tokenizer model in this file.
// ----------------------------------------------------------------------------
module tb;
    import bwt_pkg::*;

    localparam int LEN_LO  = START_W;
    localparam int STAT_LO = START_W + LEN_W;
    localparam int ERR_LO  = STAT_LO + STATUS_W;

    typedef enum logic [1:0] {
        LM_BETWEEN,
        LM_BARE,
        LM_BRACED,
        LM_FINISHED
    } line_mode_t;

    typedef struct {
        item_t   it;
        bit      pinned;
        result_t want;
    } vector_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BASE_W-1:0]     cfg_data;

    // tokenizer model state
    line_mode_t        line_mode   = LM_BETWEEN;
    int unsigned       line_pos    = 0;
    int unsigned       word_begin  = 0;
    int unsigned       brace_depth = 0;
    logic [BASE_W-1:0] pos_base    = '0;

    result_t     pending_results[$];
    item_t       line_q[$];
    vector_row_t vectors[$];
    int          mismatches = 0;
    int          live_count = 0;
    bit          tx_steady  = 1'b0;
    bit          rx_steady  = 1'b0;

    brace_word_tokenizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic result_t word_result(input int unsigned start, input int unsigned len,
                                            input status_t st);
        result_t r;
        r = '0;
        r.token_valid  = 1'b1;
        r.token_start  = START_W'(start);
        r.token_length = LEN_W'(len);
        r.status       = st;
        return r;
    endfunction

    function automatic result_t fault_result(input status_t st);
        result_t r;
        r = '0;
        r.status         = st;
        r.error_position = ERRPOS_W'(32'(pos_base) + line_pos);
        return r;
    endfunction

    // one item through the line tokenizer, state updated in place
    function automatic result_t tokenize_step(input item_t it);
        result_t r;
        bit      blank;
        r = '0;
        r.status = ST_RUNNING;
        blank = it.ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
        if (it.end_of_line) begin
            case (line_mode)
                LM_BETWEEN: r.status = ST_DONE;
                LM_BARE:    r = word_result(word_begin, line_pos - word_begin, ST_DONE);
                LM_BRACED:  r = fault_result(ST_END);
                default:    ;
            endcase
            line_mode   = LM_BETWEEN;
            line_pos    = 0;
            word_begin  = 0;
            brace_depth = 0;
            return r;
        end
        if (line_mode == LM_FINISHED)
            return r;
        if (line_pos >= MAX_LINE) begin
            line_mode = LM_FINISHED;
            return fault_result(ST_LONG);
        end
        case (line_mode)
            LM_BETWEEN: begin
                if (blank) begin
                end else if (it.ch == CH_HASH) begin
                    r.status  = ST_DONE;
                    line_mode = LM_FINISHED;
                    return r;
                end else if (it.ch == CH_OPEN) begin
                    brace_depth = 1;
                    word_begin  = line_pos + 1;
                    line_mode   = LM_BRACED;
                end else begin
                    word_begin = line_pos;
                    line_mode  = LM_BARE;
                end
            end
            LM_BARE: begin
                if (blank) begin
                    r = word_result(word_begin, line_pos - word_begin, ST_RUNNING);
                    line_mode = LM_BETWEEN;
                end else if (it.ch == CH_OPEN || it.ch == CH_CLOSE) begin
                    line_mode = LM_FINISHED;
                    return fault_result(ST_BRACE);
                end
            end
            default: begin
                if (it.ch == CH_OPEN) begin
                    if (brace_depth >= MAX_DEPTH) begin
                        line_mode = LM_FINISHED;
                        return fault_result(ST_DEPTH);
                    end
                    brace_depth++;
                end else if (it.ch == CH_CLOSE) begin
                    if (brace_depth > 0)
                        brace_depth--;
                    if (brace_depth == 0) begin
                        r = word_result(word_begin, line_pos - word_begin, ST_RUNNING);
                        line_mode = LM_BETWEEN;
                    end
                end
            end
        endcase
        line_pos++;
        return r;
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // byte of a bare word; a hash may not open one
    function automatic logic [7:0] bare_byte(input bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_OPEN, CH_CLOSE} ||
               (first && c == CH_HASH));
        return c;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_OPEN || c == CH_CLOSE);
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] c);
        item_t it;
        it.ch          = c;
        it.end_of_line = 1'b0;
        line_q.push_back(it);
    endfunction

    function automatic void push_eol();
        item_t it;
        it.ch          = 8'($urandom_range(0, 255));
        it.end_of_line = 1'b1;
        line_q.push_back(it);
    endfunction

    task automatic add_row(input logic [7:0] c, input bit eol, input bit pinned,
                           input bit tv, input int ts, input int tl, input status_t st,
                           input int ep);
        vector_row_t row;
        row.it.ch                = c;
        row.it.end_of_line       = eol;
        row.pinned               = pinned;
        row.want                 = '0;
        row.want.token_valid     = tv;
        row.want.token_start     = START_W'(ts);
        row.want.token_length    = LEN_W'(tl);
        row.want.status          = st;
        row.want.error_position  = ERRPOS_W'(ep);
        vectors.push_back(row);
    endtask

    // random command line: mostly words, some comments, noise and broken lines
    task automatic build_line();
        int  kind;
        int  words;
        int  n;
        int  d;
        line_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            n = $urandom_range(1, 24);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    push_eol();
                else
                    push_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        words = $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0)
            push_byte(ws_byte());
        for (int w = 0; w < words; w++) begin
            if ($urandom_range(0, 2) == 0) begin
                push_byte(CH_OPEN);
                d = 1;
                n = $urandom_range(0, 10);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: if (d < 4) begin
                            push_byte(CH_OPEN);
                            d++;
                        end
                        1: if (d > 1) begin
                            push_byte(CH_CLOSE);
                            d--;
                        end
                        default: push_byte(plain_byte());
                    endcase
                end
                repeat (d) push_byte(CH_CLOSE);
            end else begin
                push_byte(bare_byte(1'b1));
                n = $urandom_range(0, 7);
                repeat (n) push_byte(bare_byte(1'b0));
            end
            if (w < words - 1 || $urandom_range(0, 1) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) push_byte(ws_byte());
            end
        end
        case (kind)
            7: begin
                // brace inside a bare word, then bytes that must be ignored
                push_byte(ws_byte());
                push_byte(bare_byte(1'b1));
                n = $urandom_range(0, 3);
                repeat (n) push_byte(bare_byte(1'b0));
                push_byte($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
                n = $urandom_range(0, 4);
                repeat (n) push_byte(8'($urandom_range(0, 255)));
            end
            8: begin
                // braced word cut off by the end of line
                push_byte(ws_byte());
                push_byte(CH_OPEN);
                n = $urandom_range(0, 6);
                repeat (n) push_byte(plain_byte());
            end
            default: begin
                if ($urandom_range(0, 4) == 0) begin
                    push_byte(ws_byte());
                    push_byte(CH_HASH);
                    n = $urandom_range(0, 6);
                    repeat (n) push_byte(8'($urandom_range(0, 255)));
                end
            end
        endcase
        push_eol();
    endtask

    // style 0: one word over the whole line, 1: last word at the final
    // position, 2: three bytes past the line limit
    task automatic build_long_line(input int style);
        line_q.delete();
        for (int p = 0; p < MAX_LINE; p++) begin
            if (style == 0 || p == MAX_LINE - 1)
                push_byte(bare_byte(1'b1));
            else if (p == MAX_LINE - 2)
                push_byte(ws_byte());
            else
                push_byte(($urandom_range(0, 3) == 0) ? ws_byte() : bare_byte(1'b1));
        end
        if (style == 2)
            repeat (3) push_byte(8'($urandom_range(0, 255)));
        push_eol();
    endtask

    task automatic build_nest_line(input bit overflow);
        line_q.delete();
        repeat (MAX_DEPTH) push_byte(CH_OPEN);
        if (overflow) begin
            push_byte(CH_OPEN);
            push_byte(CH_CLOSE);
        end else begin
            push_byte(plain_byte());
            repeat (MAX_DEPTH) push_byte(CH_CLOSE);
        end
        push_eol();
    endtask

    task automatic send_item(input item_t it, input bit pinned, input result_t pin);
        int      gap;
        result_t r;
        bit      live;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= it.ch;
        s_tlast  <= it.end_of_line;
        do @(posedge aclk); while (!s_tready);
        live = it.end_of_line || line_mode != LM_FINISHED;
        r = tokenize_step(it);
        if (live)
            live_count++;
        pending_results.push_back(pinned ? pin : r);
    endtask

    task automatic send_line();
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        foreach (line_q[i])
            send_item(line_q[i], 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.token_valid    = m_tuser;
            got.token_start    = m_tdata[0 +: START_W];
            got.token_length   = m_tdata[LEN_LO +: LEN_W];
            got.status         = status_t'(m_tdata[STAT_LO +: STATUS_W]);
            got.error_position = m_tdata[ERR_LO +: ERRPOS_W];
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none pending, tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.token_valid !== want.token_valid) begin
                    $display("%0t: token_valid expected %0d got %0d",
                             $time, want.token_valid, got.token_valid);
                    mismatches++;
                end
                if (got.token_start !== want.token_start) begin
                    $display("%0t: token_start expected %0d got %0d",
                             $time, want.token_start, got.token_start);
                    mismatches++;
                end
                if (got.token_length !== want.token_length) begin
                    $display("%0t: token_length expected %0d got %0d",
                             $time, want.token_length, got.token_length);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, got.status);
                    mismatches++;
                end
                if (got.error_position !== want.error_position) begin
                    $display("%0t: error_position expected %0d got %0d",
                             $time, want.error_position, got.error_position);
                    mismatches++;
                end
                if (m_tdata[OUT_DATA_W-1:OUT_BITS] !== '0) begin
                    $display("%0t: tdata fill expected 0 got %h",
                             $time, m_tdata[OUT_DATA_W-1:OUT_BITS]);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int                target;
        logic [BASE_W-1:0] next_base;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // position_base still at its reset value of zero here
        add_row(8'h00,    1, 1, 0, 0, 0, ST_DONE,    0);
        add_row("a",      0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row("b",      0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_SPACE, 0, 1, 1, 0, 2, ST_RUNNING, 0);
        add_row(CH_OPEN,  0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_OPEN,  0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row("x",      0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_CLOSE, 0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_CLOSE, 0, 1, 1, 4, 3, ST_RUNNING, 0);
        add_row(CH_TAB,   0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(8'hff,    0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(8'h00,    0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_CR,    0, 1, 1, 9, 2, ST_RUNNING, 0);
        add_row(CH_LF,    0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row("q",      0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_OPEN,  0, 1, 0, 0, 0, ST_BRACE,   14);
        add_row("z",      0, 1, 0, 0, 0, ST_RUNNING, 0);
        add_row(8'hff,    1, 1, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_HASH,  0, 1, 0, 0, 0, ST_DONE,    0);
        add_row(CH_OPEN,  0, 1, 0, 0, 0, ST_RUNNING, 0);
        add_row(8'h00,    1, 1, 0, 0, 0, ST_RUNNING, 0);
        add_row(CH_OPEN,  0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(8'h00,    1, 1, 0, 0, 0, ST_END,     1);
        add_row(CH_CLOSE, 0, 0, 0, 0, 0, ST_RUNNING, 0);
        add_row(8'ha5,    1, 1, 1, 0, 1, ST_DONE,    0);
        foreach (vectors[i])
            send_item(vectors[i].it, vectors[i].pinned, vectors[i].want);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0:       next_base = '1;
                1:       next_base = '0;
                2:       next_base = 16'd1;
                default: next_base = BASE_W'($urandom);
            endcase
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= next_base;
            do @(posedge aclk); while (!cfg_ready);
            pos_base = next_base;
            @(negedge aclk) cfg_valid <= 1'b0;

            case (ph)
                0: begin
                    build_long_line(2);
                    send_line();
                    build_nest_line(1'b1);
                    send_line();
                end
                1: begin
                    build_nest_line(1'b0);
                    send_line();
                end
                2: begin
                    build_long_line(0);
                    send_line();
                end
                3: begin
                    build_long_line(1);
                    send_line();
                end
                default: ;
            endcase

            target = live_count + 140;
            while (live_count < target) begin
                build_line();
                send_line();
            end
        end

        drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
